@@ design/psrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrt_pkg - power state residency tracker definitions
// Operation codes and fixed field widths shared by the tracker core.
// ----------------------------------------------------------------------------
package psrt_pkg;

    localparam int OP_W    = 2;
    localparam int STATE_W = 3;
    localparam int TIME_W  = 64;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_CHANGE = 2'd1,
        OP_READ   = 2'd2,
        OP_STOP   = 2'd3
    } t_op;

    typedef logic [STATE_W-1:0] t_state;
    typedef logic [TIME_W-1:0]  t_time;

endpackage

@@ design/power_state_residency_tracker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_state_residency_tracker_core - per-state residency bookkeeping
// Keeps accumulated time, entry count and entry/exit stamps for each power
// state and answers start, change, read and stop requests.
// ----------------------------------------------------------------------------
// One request beat in, one result beat out. A request lands in an input
// register; once the result register can take it, the per-state record
// lanes compute their new contents and the result, and both are written
// on the same edge, the result into the result register. A new request is
// taken every cycle as long as the result register drains; the rate is
// one beat per cycle, set by the record update (a 64-bit accumulate in the
// tracked state's lane). Results hold while o_out_valid
// is high and i_out_stall is asserted; the input side then stalls only
// once its own register is full. Start refuses when already tracking, change
// refuses when untracked, and any state index at or above NUM_STATES is
// refused by start, change and read. Stop always succeeds and clears all
// records. Record fields of a result are zero unless it answers an accepted
// read. All sums, counts and time differences wrap modulo 2^64.
// ----------------------------------------------------------------------------
module power_state_residency_tracker_core #(
    parameter int NUM_STATES = 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [psrt_pkg::OP_W-1:0]    i_op,
    input  logic [psrt_pkg::STATE_W-1:0] i_state_index,
    input  logic                     i_from_zero,
    input  logic [psrt_pkg::TIME_W-1:0]  i_now_us,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_status,
    output logic                     o_tracking,
    output logic [psrt_pkg::STATE_W-1:0] o_current_state,
    output logic [psrt_pkg::TIME_W-1:0]  o_state_time,
    output logic [psrt_pkg::TIME_W-1:0]  o_entry_total,
    output logic [psrt_pkg::TIME_W-1:0]  o_last_entry_time,
    output logic [psrt_pkg::TIME_W-1:0]  o_last_exit_time
);
    import psrt_pkg::*;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic   r_in_valid;
    t_op    r_op;
    t_state r_idx;
    logic   r_from_zero;
    t_time  r_now;

    logic   w_fire;      // input register beat is processed this cycle
    logic   w_in_take;   // new request beat accepted this cycle

    assign w_fire     = r_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_op        <= t_op'(i_op);
            r_idx       <= i_state_index;
            r_from_zero <= i_from_zero;
            r_now       <= i_now_us;
        end
    end

    // ------------------------------------------------------------------
    // Tracker state and per-state record lanes
    // ------------------------------------------------------------------
    logic   r_tracking;
    t_state r_active;
    t_time  r_acc   [NUM_STATES];
    t_time  r_last  [NUM_STATES];
    t_time  r_cnt   [NUM_STATES];
    t_time  r_entry [NUM_STATES];
    t_time  r_exit  [NUM_STATES];

    logic   n_tracking;
    t_state n_active;
    t_time  n_acc   [NUM_STATES];
    t_time  n_last  [NUM_STATES];
    t_time  n_cnt   [NUM_STATES];
    t_time  n_entry [NUM_STATES];
    t_time  n_exit  [NUM_STATES];

    // request decode
    logic  w_idx_ok;
    logic  w_start_ok;
    logic  w_change_ok;
    logic  w_read_ok;
    logic  w_read_adv;
    logic  w_stop;
    logic  w_status;
    t_time w_enter_time;

    assign w_idx_ok = ({1'b0, r_idx} < (STATE_W + 1)'(NUM_STATES));

    always_comb begin
        w_start_ok  = 1'b0;
        w_change_ok = 1'b0;
        w_read_ok   = 1'b0;
        w_stop      = 1'b0;
        w_status    = 1'b0;
        unique case (r_op)
            OP_START: begin
                w_start_ok = w_idx_ok && !r_tracking;
                w_status   = !w_start_ok;
            end
            OP_CHANGE: begin
                // change to the tracked state is accepted and does nothing
                w_change_ok = w_idx_ok && r_tracking && (r_idx != r_active);
                w_status    = !(w_idx_ok && r_tracking);
            end
            OP_READ: begin
                w_read_ok = w_idx_ok;
                w_status  = !w_idx_ok;
            end
            OP_STOP: begin
                w_stop = 1'b1;
            end
            default: begin
                w_status = 1'b1;
            end
        endcase
    end

    assign w_read_adv   = w_read_ok && r_tracking && (r_idx == r_active);
    assign w_enter_time = (w_start_ok && r_from_zero) ? '0 : r_now;

    // each lane only looks at its own record
    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            logic is_act;
            logic hit;
            logic adv;
            logic ent;
            is_act = (r_active == STATE_W'(i));
            hit    = (r_idx == STATE_W'(i));
            adv    = (w_change_ok || w_read_adv) && is_act;
            ent    = (w_start_ok || w_change_ok) && hit;

            n_acc[i]   = r_acc[i];
            n_last[i]  = r_last[i];
            n_cnt[i]   = r_cnt[i];
            n_entry[i] = r_entry[i];
            n_exit[i]  = r_exit[i];

            if (w_stop) begin
                n_acc[i]   = '0;
                n_last[i]  = '0;
                n_cnt[i]   = '0;
                n_entry[i] = '0;
                n_exit[i]  = '0;
            end else begin
                if (adv) begin
                    n_acc[i]  = r_acc[i] + (r_now - r_last[i]);
                    n_last[i] = r_now;
                end
                if (w_change_ok && is_act) begin
                    n_exit[i] = r_now;
                end
                if (ent) begin
                    n_last[i]  = w_enter_time;
                    n_cnt[i]   = r_cnt[i] + TIME_W'(1);
                    n_entry[i] = w_enter_time;
                end
            end
        end
    end

    always_comb begin
        n_tracking = r_tracking;
        n_active   = r_active;
        if (w_stop) begin
            n_tracking = 1'b0;
            n_active   = '0;
        end else if (w_start_ok || w_change_ok) begin
            n_tracking = 1'b1;
            n_active   = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking <= 1'b0;
            r_active   <= '0;
            for (int i = 0; i < NUM_STATES; i++) begin
                r_acc[i]   <= '0;
                r_last[i]  <= '0;
                r_cnt[i]   <= '0;
                r_entry[i] <= '0;
                r_exit[i]  <= '0;
            end
        end else if (w_fire) begin
            r_tracking <= n_tracking;
            r_active   <= n_active;
            for (int i = 0; i < NUM_STATES; i++) begin
                r_acc[i]   <= n_acc[i];
                r_last[i]  <= n_last[i];
                r_cnt[i]   <= n_cnt[i];
                r_entry[i] <= n_entry[i];
                r_exit[i]  <= n_exit[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result select: updated record of the queried lane, zero otherwise
    // ------------------------------------------------------------------
    t_time w_sel_acc;
    t_time w_sel_cnt;
    t_time w_sel_entry;
    t_time w_sel_exit;

    always_comb begin
        w_sel_acc   = '0;
        w_sel_cnt   = '0;
        w_sel_entry = '0;
        w_sel_exit  = '0;
        for (int i = 0; i < NUM_STATES; i++) begin
            if (w_read_ok && (r_idx == STATE_W'(i))) begin
                w_sel_acc   = n_acc[i];
                w_sel_cnt   = n_cnt[i];
                w_sel_entry = n_entry[i];
                w_sel_exit  = n_exit[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic   r_out_valid;
    logic   r_status;
    logic   r_out_tracking;
    t_state r_out_state;
    t_time  r_out_acc;
    t_time  r_out_cnt;
    t_time  r_out_entry;
    t_time  r_out_exit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status       <= w_status;
            r_out_tracking <= n_tracking;
            r_out_state    <= n_tracking ? n_active : '0;
            r_out_acc      <= w_sel_acc;
            r_out_cnt      <= w_sel_cnt;
            r_out_entry    <= w_sel_entry;
            r_out_exit     <= w_sel_exit;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_tracking        = r_out_tracking;
    assign o_current_state   = r_out_state;
    assign o_state_time      = r_out_acc;
    assign o_entry_total     = r_out_cnt;
    assign o_last_entry_time = r_out_entry;
    assign o_last_exit_time  = r_out_exit;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_active_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_active} < (STATE_W + 1)'(NUM_STATES)))
        else $error("active state out of range");

    a_idle_active_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_tracking |-> (r_active == '0))
        else $error("active state set while untracked");

    a_untracked_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_tracking) |-> (o_current_state == '0))
        else $error("untracked result reports a state");

    a_reject_no_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
            (o_state_time == '0 && o_entry_total == '0 &&
             o_last_entry_time == '0 && o_last_exit_time == '0))
        else $error("rejected beat carries record data");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");

endmodule
